>>> rtl/nfba_pkg.sv
// Shared types, constants and helper functions of the next-fit bitmap allocator.
`default_nettype none

package nfba_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;

  localparam int IDX_W  = 10;  // entry number
  localparam int CNT_W  = 11;  // free count, totals and scan position
  localparam int WIDX_W = 5;   // word number within the map
  localparam int BIT_W  = 5;   // bit number within a word
  localparam int POP_W  = 6;   // popcount of one word
  localparam int ADDR_W = 3;   // configuration byte address

  // Register number on the configuration port (byte address / 4).
  localparam logic REG_INODE_TOTAL = 1'b0;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAX_ENTRIES);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_LOAD  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;    // take the request and set up the scan window
    logic load_step;  // write the captured word and adjust the count
    logic scan_step;  // examine one bitmap word
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;        // a free entry was found in the current word
    logic scan_end;   // the whole window was examined without a hit
  } dp_status_t;

  // Number of set bits, counted per nibble and then summed.
  function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [2:0]       nib [WORD_BITS/4];
    logic [POP_W-1:0] sum;
    sum = '0;
    for (int n = 0; n < WORD_BITS / 4; n++) begin
      nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
    end
    for (int n = 0; n < WORD_BITS / 4; n++) begin
      sum = sum + POP_W'(nib[n]);
    end
    return sum;
  endfunction

  // Position of the lowest set bit; zero when no bit is set.
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] low;
    logic [BIT_W-1:0]     pos;
    low = v & (~v + WORD_BITS'(1));
    pos = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> k) & 1) != 0) begin
          pos[k] = pos[k] | low[i];
        end
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> rtl/nfba_ctrl.sv
// Sequencing state machine of the next-fit bitmap allocator.
`default_nettype none

module nfba_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 operation,
  input  wire nfba_pkg::dp_status_t status,
  output nfba_pkg::dp_cmd_t         cmd,
  output logic                      busy,
  output logic                      strobe
);
  import nfba_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (operation == OP_LOAD) ? ST_LOAD : ST_SCAN;
        end
      end
      ST_LOAD: state_next = ST_DONE;
      ST_SCAN: begin
        if (status.hit || status.scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    busy          = 1'b1;
    strobe        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_LOAD: cmd.load_step = 1'b1;
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_DONE: strobe = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/nfba_dp.sv
// Datapath of the next-fit bitmap allocator: bitmap, counters and word scanner.
`default_nettype none

module nfba_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire nfba_pkg::dp_cmd_t             cmd,
  input  wire logic [nfba_pkg::CNT_W-1:0]    total,
  input  wire logic [nfba_pkg::WIDX_W-1:0]   word_index,
  input  wire logic [nfba_pkg::WORD_BITS-1:0] word_bits,
  output nfba_pkg::dp_status_t               status,
  output logic [nfba_pkg::IDX_W-1:0]         entry_index,
  output logic                               found,
  output logic [nfba_pkg::CNT_W-1:0]         free_count
);
  import nfba_pkg::*;

  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

  logic [WORD_BITS-1:0] free_map [MAP_WORDS];
  logic [CNT_W-1:0]     scan_position;
  logic [CNT_W-1:0]     free_counter;

  // Scan window, fixed at capture, with the current word and wrap flag of the scan.
  logic [CNT_W-1:0]     tot;
  logic                 tot_zero;
  logic [WIDX_W-1:0]    start_word;
  logic [BIT_W-1:0]     start_bit;
  logic [WIDX_W-1:0]    last_word;
  logic [BIT_W-1:0]     last_bit;
  logic [WIDX_W-1:0]    cur_word;
  logic                 wrapped;

  logic [WIDX_W-1:0]    load_index;
  logic [WORD_BITS-1:0] load_bits;

  // Capture-time window setup.
  logic [CNT_W-1:0]     tot_next;
  logic [CNT_W-1:0]     pos_eff;
  logic [CNT_W-1:0]     tot_m1;

  always_comb begin
    tot_next = (total > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : total;
    pos_eff  = (scan_position >= tot_next) ? '0 : scan_position;
    tot_m1   = tot_next - CNT_W'(1);
  end

  // One word of the scan.
  logic [WORD_BITS-1:0] cur_bits;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] wrap_mask;
  logic [WORD_BITS-1:0] masked;
  logic [BIT_W-1:0]     hit_bit;
  logic [IDX_W-1:0]     hit_index;
  logic [CNT_W-1:0]     pos_after;
  logic                 at_start;
  logic                 hit;

  always_comb begin
    cur_bits  = free_map[cur_word];
    at_start  = (cur_word == start_word);
    lo_mask   = (at_start && !wrapped) ? (ALL_ONES << start_bit) : ALL_ONES;
    wrap_mask = (at_start && wrapped) ? ((WORD_BITS'(1) << start_bit) - WORD_BITS'(1))
                                      : ALL_ONES;
    hi_mask   = (cur_word == last_word) ? (ALL_ONES >> (BIT_W'(WORD_BITS - 1) - last_bit))
                                        : ALL_ONES;
    masked    = cur_bits & lo_mask & wrap_mask & hi_mask & {WORD_BITS{!tot_zero}};
    hit       = |masked;
    hit_bit   = lowest_bit(masked);
    hit_index = {cur_word, hit_bit};
    pos_after = CNT_W'(hit_index) + CNT_W'(1);
    if (pos_after == tot) begin
      pos_after = '0;
    end
    status.hit      = hit;
    status.scan_end = !hit && (tot_zero || (wrapped && at_start));
  end

  // Load: count moves by the popcount difference.
  logic [WORD_BITS-1:0] old_bits;
  logic [CNT_W-1:0]     count_loaded;

  always_comb begin
    old_bits     = free_map[load_index];
    count_loaded = free_counter - CNT_W'(popcount(old_bits)) + CNT_W'(popcount(load_bits));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        free_map[w] <= '0;
      end
      scan_position <= '0;
      free_counter  <= '0;
      cur_word      <= '0;
      wrapped       <= 1'b0;
      found         <= 1'b0;
      entry_index   <= '0;
    end else begin
      if (cmd.capture) begin
        tot         <= tot_next;
        tot_zero    <= (tot_next == '0);
        start_word  <= pos_eff[BIT_W +: WIDX_W];
        start_bit   <= pos_eff[BIT_W-1:0];
        last_word   <= tot_m1[BIT_W +: WIDX_W];
        last_bit    <= tot_m1[BIT_W-1:0];
        cur_word    <= pos_eff[BIT_W +: WIDX_W];
        wrapped     <= 1'b0;
        load_index  <= word_index;
        load_bits   <= word_bits;
        found       <= 1'b0;
        entry_index <= '0;
      end
      if (cmd.load_step) begin
        free_map[load_index] <= load_bits;
        free_counter         <= count_loaded;
      end
      if (cmd.scan_step) begin
        if (hit) begin
          free_map[cur_word][hit_bit] <= 1'b0;
          free_counter  <= free_counter - CNT_W'(1);
          scan_position <= pos_after;
          entry_index   <= hit_index;
          found         <= 1'b1;
        end else if (cur_word == last_word && !wrapped) begin
          cur_word <= '0;
          wrapped  <= 1'b1;
        end else begin
          cur_word <= cur_word + WIDX_W'(1);
        end
      end
    end
  end

  assign free_count = free_counter;

endmodule

`default_nettype wire

>>> rtl/next_fit_bitmap_allocator.sv
// Top level of the next-fit bitmap allocator: configuration port, controller and datapath.
`default_nettype none

// Usage
// The block hands out entries from a bitmap of 1024 entries held in 32 words
// of 32 bits, where a set bit marks a free entry. A request is a transfer on
// the command channel: it is taken at a rising edge with start high and busy
// low. operation selects an allocation or the load of one whole bitmap word
// (word_index, word_bits); loads are how software fills the map after reset.
// Allocation searches circularly from the scan position over inode_total
// entries, one bitmap word per cycle, and takes the lowest free entry it meets.
// Each request gives exactly one result transfer: strobe is high for one cycle
// with entry_index, found and free_count, and the receiver cannot stall it.
// A load passes through the load and done states; an allocation passes through
// the scan state, where the word scanner visits up to 33 words (the start word
// is seen twice when the search wraps), then the done state. A new request is
// accepted in the cycle after the strobe. Reset clears the map (nothing free),
// the scan position and the free count, and sets inode_total to 1024. It is
// written over the APB-style port at byte address 0, by the user only while
// the block is idle (the block does not enforce this); stored values above 1024 act as 1024.

module next_fit_bitmap_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nfba_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            operation,
  input  wire logic [nfba_pkg::WIDX_W-1:0]     word_index,
  input  wire logic [nfba_pkg::WORD_BITS-1:0]  word_bits,
  // result channel
  output logic                                 strobe,
  output logic [nfba_pkg::IDX_W-1:0]           entry_index,
  output logic                                 found,
  output logic [nfba_pkg::CNT_W-1:0]           free_count
);
  import nfba_pkg::*;

  // The inode_total register. Only the low 11 bits of a write are kept.
  logic [CNT_W-1:0] inode_total;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inode_total <= TOTAL_RESET;
    end else if (cfg_write && paddr[2] == REG_INODE_TOTAL) begin
      inode_total <= pwdata[CNT_W-1:0];
    end
  end

  // Reads return the register at its address and zero elsewhere.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_INODE_TOTAL) begin
      prdata = 32'(inode_total);
    end
  end

  // The controller sequences each transfer; the datapath holds the bitmap, counters and scan window.
  dp_cmd_t    cmd;
  dp_status_t status;

  nfba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .strobe    (strobe)
  );

  nfba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .total       (inode_total),
    .word_index  (word_index),
    .word_bits   (word_bits),
    .status      (status),
    .entry_index (entry_index),
    .found       (found),
    .free_count  (free_count)
  );

  // A result is only ever shown while a request is in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe outside a request");

  // An accepted request makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // One result per request: the strobe is never held high.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe held for two cycles");

  // A successful allocation takes exactly one entry off the free count.
  a_count_drop: assert property (@(posedge clk) disable iff (rst)
    (strobe && found && !$past(rst)) |-> (free_count == CNT_W'($past(free_count) - CNT_W'(1))))
    else $error("free count not decremented on allocation");

endmodule

`default_nettype wire
